// ===== hw/rtl/dnga_pkg.sv =====
package dnga_pkg;

  localparam int unsigned MaxDerivsDefault = 8;
  localparam int unsigned FracBitsDefault  = 16;
  localparam int unsigned Slots            = 8;

  typedef enum logic [2:0] {
    OpConst  = 3'd0,
    OpSeed   = 3'd1,
    OpLoad   = 3'd2,
    OpMul    = 3'd3,
    OpDiv    = 3'd4,
    OpAdd    = 3'd5,
    OpSub    = 3'd6,
    OpResize = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    ErrOk   = 2'd0,
    ErrSeed = 2'd1,
    ErrDz   = 2'd2,
    ErrSat  = 2'd3
  } err_e;

  typedef enum logic [2:0] {
    StIdle,
    StMulA,
    StMulB,
    StDivStart,
    StDivWait,
    StSlotDone,
    StOut
  } state_e;

  function automatic logic [31:0] sat32(input logic signed [65:0] v, output logic hit);
    hit = 1'b0;
    if (v > 66'sd2147483647) begin
      hit = 1'b1;
      return 32'h7fffffff;
    end
    if (v < -66'sd2147483648) begin
      hit = 1'b1;
      return 32'h80000000;
    end
    return v[31:0];
  endfunction

endpackage

// ===== hw/rtl/dnga_div.sv =====
// restoring divider, one quotient bit per cycle, result (x << FracBits) / y
// truncated toward zero and saturated
module dnga_div #(
  parameter int unsigned FracBits = dnga_pkg::FracBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] x_i,
  input  logic [31:0] y_i,
  output logic        done_o,
  output logic [31:0] q_o,
  output logic        dz_o,
  output logic        sat_o
);
  localparam int unsigned NumW = 32 + FracBits;
  localparam int unsigned CntW = $clog2(NumW + 1);

  logic            busy_q, busy_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [NumW-1:0] num_q, num_d;
  logic [32:0]     rem_q, rem_d;
  logic [31:0]     den_q, den_d;
  logic            neg_q, neg_d;
  logic            done_q, done_d;
  logic [31:0]     q_q, q_d;
  logic            dz_q, dz_d;
  logic            sat_q, sat_d;
  logic [32:0]     shifted;
  logic            fit;
  logic [NumW:0]   mag;
  logic            hit;
  logic [NumW-1:0] ax;

  assign ax = {{FracBits{1'b0}}, (x_i[31] ? (~x_i + 32'd1) : x_i)} << FracBits;
  assign shifted = {rem_q[31:0], num_q[NumW-1]};
  assign fit = shifted >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q; cnt_d = cnt_q; num_d = num_q; rem_d = rem_q; den_d = den_q;
    neg_d = neg_q; done_d = 1'b0; q_d = q_q; dz_d = dz_q; sat_d = sat_q;
    mag = '0; hit = 1'b0;
    if (start_i) begin
      dz_d = 1'b0; sat_d = 1'b0;
      if (y_i == 32'd0) begin
        done_d = 1'b1; dz_d = 1'b1;
        q_d = (x_i == 32'd0) ? 32'd0 : (x_i[31] ? 32'h80000000 : 32'h7fffffff);
      end else begin
        busy_d = 1'b1;
        cnt_d = CntW'(NumW);
        num_d = ax;
        rem_d = '0;
        den_d = y_i[31] ? (~y_i + 32'd1) : y_i;
        neg_d = x_i[31] ^ y_i[31];
      end
    end else if (busy_q) begin
      rem_d = fit ? (shifted - {1'b0, den_q}) : shifted;
      num_d = {num_q[NumW-2:0], fit};
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        mag = {1'b0, num_q[NumW-2:0], fit};
        q_d = dnga_pkg::sat32(neg_q ? -$signed(66'(mag)) : $signed(66'(mag)), hit);
        sat_d = hit;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d; rem_q <= rem_d; den_q <= den_d; neg_q <= neg_d;
    q_q <= q_d; dz_q <= dz_d; sat_q <= sat_d;
  end

  assign done_o = done_q;
  assign q_o = q_q;
  assign dz_o = dz_q;
  assign sat_o = sat_q;
endmodule

// ===== hw/rtl/dual_number_gradient_alu_unit.sv =====
// dual number gradient alu
// one input beat on s_axis carries op, operand value, count, seed index and
// eight operand derivatives; one output beat on m_axis carries the updated
// accumulator (value, count, derivatives, error code)
// the block works one beat at a time: s_axis_tready is high only when idle
// and the previous result has been taken
// load/add/sub/resize go straight from idle to the output state; mul runs
// each slot through StMulA, StMulB and StSlotDone on one shared 32x32
// multiplier, then a last StMulA for the value; div takes the value
// quotient, then per slot a multiply and a quotient, up to nine quotients
// through one restoring divider of 32+FRAC_BITS numerator bits
// reset clears the accumulator to zero value, zero count, zero derivatives
// a stalled m_axis holds the result beat and no new beat is accepted
module dual_number_gradient_alu_unit #(
  parameter int unsigned MaxDerivs = dnga_pkg::MaxDerivsDefault,
  parameter int unsigned FracBits  = dnga_pkg::FracBitsDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // op[2:0], operand_value[34:3], operand_count[38:35], seed_index[41:39],
  // operand_d0..d7 [297:42], zero pad to 304
  input  logic [303:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // result_value[31:0], result_count[35:32], result_d0..d7 [291:36],
  // error[293:292], zero pad to 296
  output logic [295:0] m_axis_tdata
);
  localparam int unsigned S = dnga_pkg::Slots;

  dnga_pkg::state_e st_q, st_d;

  logic [31:0] a_q, a_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [31:0] g_q [S];
  logic [31:0] g_d [S];
  logic [31:0] b_q, b_d;
  logic [31:0] db_q [S];
  logic [31:0] db_d [S];
  logic [2:0]  op_q, op_d;
  logic [3:0]  maxc_q, maxc_d;
  logic [2:0]  k_q, k_d;
  logic        vstep_q, vstep_d;   // value step pending (mul) or done (div)
  logic [31:0] qv_q, qv_d;
  logic signed [65:0] accp_q, accp_d;
  logic        dz_q, dz_d, sat_q, sat_d;
  logic [1:0]  err_q, err_d;
  logic        ov_q, ov_d;

  // shared multiplier
  logic signed [31:0] mx, my;
  logic signed [63:0] prod;
  logic signed [65:0] prod_f;

  // divider
  logic        dv_start;
  logic [31:0] dv_x, dv_y, dv_q;
  logic        dv_done, dv_dz, dv_sat;

  logic [2:0]  in_op;
  logic [31:0] in_b;
  logic [3:0]  in_n_raw, in_n;
  logic [2:0]  in_seed;
  logic        hit;
  logic [31:0] sv;
  logic        last_slot;

  dnga_div #(.FracBits(FracBits)) u_div (
    .clk_i, .rst_ni, .start_i(dv_start), .x_i(dv_x), .y_i(dv_y),
    .done_o(dv_done), .q_o(dv_q), .dz_o(dv_dz), .sat_o(dv_sat)
  );

  assign in_op    = s_axis_tdata[2:0];
  assign in_b     = s_axis_tdata[34:3];
  assign in_n_raw = s_axis_tdata[38:35];
  assign in_seed  = s_axis_tdata[41:39];
  assign in_n     = (in_n_raw > 4'(MaxDerivs)) ? 4'(MaxDerivs) : in_n_raw;

  assign prod   = mx * my;
  // floor shift of the product
  assign prod_f = 66'(prod >>> FracBits);

  assign last_slot = ({1'b0, k_q} == (maxc_q - 4'd1)) || (maxc_q == 4'd0);

  // multiplier operand select
  always_comb begin
    mx = '0; my = '0;
    if (st_q == dnga_pkg::StMulA) begin
      if (vstep_q && op_q == dnga_pkg::OpMul) begin
        mx = a_q; my = b_q;
      end else if (op_q == dnga_pkg::OpMul) begin
        mx = b_q; my = g_q[k_q];
      end else begin
        mx = qv_q; my = db_q[k_q];
      end
    end else if (st_q == dnga_pkg::StMulB) begin
      mx = a_q; my = db_q[k_q];
    end
  end

  // next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      dnga_pkg::StIdle:
        if (s_axis_tvalid && s_axis_tready) begin
          unique case (dnga_pkg::op_e'(in_op))
            dnga_pkg::OpMul: st_d = dnga_pkg::StMulA;
            dnga_pkg::OpDiv: st_d = dnga_pkg::StDivStart;
            default:         st_d = dnga_pkg::StOut;
          endcase
        end
      dnga_pkg::StMulA:
        if (op_q == dnga_pkg::OpMul) begin
          if (vstep_q) st_d = dnga_pkg::StOut;
          else         st_d = dnga_pkg::StMulB;
        end else begin
          st_d = dnga_pkg::StDivStart;
        end
      dnga_pkg::StMulB:     st_d = dnga_pkg::StSlotDone;
      dnga_pkg::StDivStart: st_d = dnga_pkg::StDivWait;
      dnga_pkg::StDivWait:
        if (dv_done) begin
          if (!vstep_q) st_d = dnga_pkg::StSlotDone;
          else          st_d = dnga_pkg::StSlotDone;
        end
      dnga_pkg::StSlotDone: begin
        if (op_q == dnga_pkg::OpMul) begin
          st_d = dnga_pkg::StMulA;
        end else if (last_slot && vstep_q) begin
          st_d = dnga_pkg::StOut;
        end else if (maxc_q == 4'd0) begin
          st_d = dnga_pkg::StOut;
        end else begin
          st_d = dnga_pkg::StMulA;
        end
      end
      dnga_pkg::StOut:
        if (m_axis_tready) st_d = dnga_pkg::StIdle;
      default: st_d = dnga_pkg::StIdle;
    endcase
  end

  // datapath
  always_comb begin
    a_d = a_q; cnt_d = cnt_q; b_d = b_q; op_d = op_q; maxc_d = maxc_q; k_d = k_q;
    vstep_d = vstep_q; qv_d = qv_q; accp_d = accp_q; dz_d = dz_q; sat_d = sat_q;
    err_d = err_q; ov_d = ov_q;
    g_d = g_q; db_d = db_q;
    dv_start = 1'b0; dv_x = '0; dv_y = b_q;
    hit = 1'b0; sv = '0;
    unique case (st_q)
      dnga_pkg::StIdle:
        if (s_axis_tvalid && s_axis_tready) begin
          op_d = in_op; b_d = in_b;
          for (int i = 0; i < S; i++) begin
            db_d[i] = (i < int'(in_n) && i < int'(MaxDerivs)) ?
                      s_axis_tdata[42+32*i +: 32] : 32'd0;
          end
          maxc_d = (cnt_q > in_n) ? cnt_q : in_n;
          k_d = '0; vstep_d = 1'b0; dz_d = 1'b0; sat_d = 1'b0; err_d = dnga_pkg::ErrOk;
          unique case (dnga_pkg::op_e'(in_op))
            dnga_pkg::OpConst: begin
              a_d = in_b; cnt_d = '0;
              for (int i = 0; i < S; i++) g_d[i] = '0;
            end
            dnga_pkg::OpSeed:
              if ({1'b0, in_seed} >= in_n) begin
                err_d = dnga_pkg::ErrSeed;
              end else begin
                a_d = in_b; cnt_d = in_n;
                for (int i = 0; i < S; i++)
                  g_d[i] = (i == int'(in_seed)) ? (32'd1 << FracBits) : 32'd0;
              end
            dnga_pkg::OpLoad: begin
              a_d = in_b; cnt_d = in_n;
              for (int i = 0; i < S; i++)
                g_d[i] = (i < int'(in_n) && i < int'(MaxDerivs)) ?
                         s_axis_tdata[42+32*i +: 32] : 32'd0;
            end
            dnga_pkg::OpAdd, dnga_pkg::OpSub: begin
              cnt_d = maxc_d;
              for (int i = 0; i < S; i++) begin
                g_d[i] = dnga_pkg::sat32((in_op == dnga_pkg::OpAdd) ?
                  66'($signed(g_q[i])) + 66'($signed(db_d[i])) :
                  66'($signed(g_q[i])) - 66'($signed(db_d[i])), hit);
                if (i >= int'(maxc_d)) g_d[i] = '0;
                else if (hit) sat_d = 1'b1;
              end
              a_d = dnga_pkg::sat32((in_op == dnga_pkg::OpAdd) ?
                66'($signed(a_q)) + 66'($signed(in_b)) :
                66'($signed(a_q)) - 66'($signed(in_b)), hit);
              if (hit) sat_d = 1'b1;
            end
            dnga_pkg::OpResize: begin
              cnt_d = in_n;
              for (int i = 0; i < S; i++) g_d[i] = '0;
            end
            default: begin
              // mul and div run through the shared units
              vstep_d = (in_op == dnga_pkg::OpMul) && (maxc_d == 4'd0);
            end
          endcase
        end
      dnga_pkg::StMulA: begin
        accp_d = prod_f;
        if (op_q == dnga_pkg::OpMul && vstep_q) begin
          a_d = dnga_pkg::sat32(prod_f, hit);
          if (hit) sat_d = 1'b1;
          cnt_d = maxc_q;
          for (int i = 0; i < S; i++) if (i >= int'(maxc_q)) g_d[i] = '0;
        end
      end
      dnga_pkg::StMulB: begin
        sv = dnga_pkg::sat32(accp_q + prod_f, hit);
        g_d[k_q] = sv;
        if (hit) sat_d = 1'b1;
      end
      dnga_pkg::StDivStart: begin
        dv_start = 1'b1;
        if (!vstep_q) begin
          dv_x = a_q;
        end else begin
          sv = dnga_pkg::sat32(66'($signed(g_q[k_q])) - accp_q, hit);
          if (hit) sat_d = 1'b1;
          dv_x = sv;
        end
      end
      dnga_pkg::StDivWait:
        if (dv_done) begin
          if (dv_dz) dz_d = 1'b1;
          if (dv_sat) sat_d = 1'b1;
          if (!vstep_q) qv_d = dv_q;
          else g_d[k_q] = dv_q;
        end
      dnga_pkg::StSlotDone: begin
        if (op_q == dnga_pkg::OpMul) begin
          if (last_slot) vstep_d = 1'b1;
          else k_d = k_q + 3'd1;
        end else begin
          if (!vstep_q) begin
            vstep_d = 1'b1;
          end else if (!last_slot) begin
            k_d = k_q + 3'd1;
          end
          if ((vstep_q && last_slot) || maxc_q == 4'd0) begin
            a_d = qv_q; cnt_d = maxc_q;
            for (int i = 0; i < S; i++) if (i >= int'(maxc_q)) g_d[i] = '0;
          end
        end
      end
      dnga_pkg::StOut: ;
      default: ;
    endcase
    if (st_q != dnga_pkg::StOut && st_d == dnga_pkg::StOut && err_d == dnga_pkg::ErrOk) begin
      if (dz_d) err_d = dnga_pkg::ErrDz;
      else if (sat_d) err_d = dnga_pkg::ErrSat;
    end
    ov_d = (st_d == dnga_pkg::StOut);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= dnga_pkg::StIdle;
      a_q <= '0; cnt_q <= '0; ov_q <= 1'b0;
      for (int i = 0; i < S; i++) g_q[i] <= '0;
    end else begin
      st_q <= st_d;
      a_q <= a_d; cnt_q <= cnt_d; ov_q <= ov_d;
      g_q <= g_d;
    end
  end

  always_ff @(posedge clk_i) begin
    b_q <= b_d; db_q <= db_d; op_q <= op_d; maxc_q <= maxc_d; k_q <= k_d;
    vstep_q <= vstep_d; qv_q <= qv_d; accp_q <= accp_d; dz_q <= dz_d;
    sat_q <= sat_d; err_q <= err_d;
  end

  assign s_axis_tready = (st_q == dnga_pkg::StIdle);
  assign m_axis_tvalid = ov_q;
  always_comb begin
    m_axis_tdata = '0;
    m_axis_tdata[31:0]  = a_q;
    m_axis_tdata[35:32] = cnt_q;
    for (int i = 0; i < S; i++) m_axis_tdata[36+32*i +: 32] = g_q[i];
    m_axis_tdata[293:292] = err_q;
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready while result pending");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[35:32] <= 4'(MaxDerivs))
    else $error("derivative count out of range");
endmodule
